FILE: hdl/mcb_pkg.sv
// Shared types and constants for the masked cell blitter.
// No dependencies; imported by every module of the block.
package mcb_pkg;

    localparam int unsigned LINE_STRIDE = 320;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned PAL_AW  = 8;
    localparam int unsigned IN_W    = 112;
    localparam int unsigned OUT_W   = 40;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MASK  = 2'd2;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // palette port: one write and one registered read per cycle
    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [PAL_AW-1:0] raddr;
    } pal_req_t;

    // operands of the shared multiply-add unit: a * b + c
    typedef struct packed {
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic [ADDR_W-1:0]  c;
    } mac_op_t;

endpackage

FILE: hdl/mcb_palette.sv
// 256-entry colour palette with per-entry valid bits; unwritten entries read as zero.
// Depends on mcb_pkg.
module mcb_palette (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mcb_pkg::pal_req_t         req,
    output logic [mcb_pkg::BYTE_W-1:0] rdata
);
    import mcb_pkg::*;

    localparam int unsigned DEPTH = 1 << PAL_AW;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [BYTE_W-1:0] rd_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

FILE: hdl/mcb_mac.sv
// Shared 16x16 multiply-add unit used for all start-command address arithmetic.
// Depends on mcb_pkg.
module mcb_mac (
    input  mcb_pkg::mac_op_t           op,
    output logic [mcb_pkg::ADDR_W-1:0] result
);
    import mcb_pkg::*;

    logic [2*COORD_W-1:0] prod;

    assign prod   = op.a * op.b;
    assign result = ADDR_W'(prod) + op.c;

endmodule

FILE: hdl/masked_cell_blitter.sv
// Masked cell blitter top level: command decode, start sequencer, pixel stepping.
// Depends on mcb_pkg, mcb_palette, mcb_mac.
//
// Input stream (s_axis): tuser carries the command; tdata the operand fields.
// Load writes one palette byte and gives no result. Start latches a cell and,
// unless width or height is zero, gives one mask fetch address transaction.
// Each mask byte while a cell is active gives one pixel write transaction;
// the final pixel of the cell has tlast set. Mask bytes while idle are dropped.
// Output stream (m_axis): one registered transaction, tuser is the kind.
// Throughput: loads and mask bytes are taken back to back, so pixels stream at one
// per cycle while the receiver keeps up. A non-empty start makes four passes through
// the shared multiply-add unit (w*h, sprite*wh+mask_base, y*stride+screen_base, +x),
// then posts the fetch address from ST_EMIT; tready is low during that time.
// A pixel's m_axis_tvalid rises the cycle after its mask byte is accepted.
// A stalled receiver holds the output register; tready drops until it drains.
// Reset returns the block to idle and clears the palette via valid bits,
// with no clearing pass; screen_base resets to zero.
module masked_cell_blitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mcb_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // colour_index, palette_value, sprite_index, pos_x, pos_y,
    // cell_width, cell_height, mask_base, mask_byte
    input  logic [mcb_pkg::IN_W-1:0]      s_axis_tdata,
    // cmd
    input  logic [mcb_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // address, pixel
    output logic [mcb_pkg::OUT_W-1:0]     m_axis_tdata,
    // kind
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import mcb_pkg::*;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_WH   = 3'd1;
    localparam logic [2:0] ST_SPR  = 3'd2;
    localparam logic [2:0] ST_DST  = 3'd3;
    localparam logic [2:0] ST_PX   = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [ADDR_W-1:0]  ROW_STEP   = ADDR_W'(LINE_STRIDE + 1);
    localparam logic [COORD_W-1:0] STRIDE_OPD = COORD_W'(LINE_STRIDE);

    logic [BYTE_W-1:0]  in_cidx, in_pval, in_sprite, in_w, in_h, in_mbyte;
    logic [COORD_W-1:0] in_px, in_py;
    logic [ADDR_W-1:0]  in_mbase;

    assign in_cidx   = s_axis_tdata[7:0];
    assign in_pval   = s_axis_tdata[15:8];
    assign in_sprite = s_axis_tdata[23:16];
    assign in_px     = s_axis_tdata[39:24];
    assign in_py     = s_axis_tdata[55:40];
    assign in_w      = s_axis_tdata[63:56];
    assign in_h      = s_axis_tdata[71:64];
    assign in_mbase  = s_axis_tdata[103:72];
    assign in_mbyte  = s_axis_tdata[111:104];

    logic [2:0]         state_reg, state_next;
    logic               busy_reg, busy_next;
    logic [BYTE_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic [BYTE_W-1:0]  width_reg, width_next, height_reg, height_next;
    logic [BYTE_W-1:0]  sprite_reg, sprite_next, fill_reg, fill_next;
    logic [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [ADDR_W-1:0]  mbase_reg, mbase_next, acc_reg, acc_next;
    logic [ADDR_W-1:0]  dest_reg, dest_next, screen_base_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next, out_last_reg, out_last_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [BYTE_W-1:0]  out_pixel_reg, out_pixel_next;

    logic               accept, out_free, row_end, final_px;
    logic [BYTE_W-1:0]  pal_rdata;
    logic [ADDR_W-1:0]  mac_result;
    pal_req_t           pal_req;
    mac_op_t            mac_op;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pal_req.we    = accept && (s_axis_tuser == CMD_LOAD);
    assign pal_req.waddr = in_cidx;
    assign pal_req.wdata = in_pval;
    assign pal_req.raddr = in_cidx;

    mcb_palette u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pal_req),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        mac_op = '0;
        unique case (state_reg)
            ST_WH:
            begin
                mac_op.a = COORD_W'(width_reg);
                mac_op.b = COORD_W'(height_reg);
            end
            ST_SPR:
            begin
                mac_op.a = COORD_W'(sprite_reg);
                mac_op.b = acc_reg[COORD_W-1:0];
                mac_op.c = mbase_reg;
            end
            ST_DST:
            begin
                mac_op.a = py_reg;
                mac_op.b = STRIDE_OPD;
                mac_op.c = screen_base_reg;
            end
            ST_PX:
            begin
                mac_op.a = COORD_W'(1);
                mac_op.b = px_reg;
                mac_op.c = dest_reg;
            end
            default:
            begin
                mac_op = '0;
            end
        endcase
    end

    mcb_mac u_mac (
        .op     (mac_op),
        .result (mac_result)
    );

    assign row_end  = BYTE_W'(col_reg + 1'b1) == width_reg;
    assign final_px = row_end && (BYTE_W'(row_reg + 1'b1) == height_reg);

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        sprite_next    = sprite_reg;
        fill_next      = fill_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        mbase_next     = mbase_reg;
        acc_next       = acc_reg;
        dest_next      = dest_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        CMD_START:
                        begin
                            width_next  = in_w;
                            height_next = in_h;
                            sprite_next = in_sprite;
                            px_next     = in_px;
                            py_next     = in_py;
                            mbase_next  = in_mbase;
                            col_next    = '0;
                            row_next    = '0;
                            busy_next   = 1'b0;
                            if (in_w != '0 && in_h != '0)
                            begin
                                state_next = ST_WH;
                            end
                        end
                        CMD_MASK:
                        begin
                            if (busy_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_PIXEL;
                                out_addr_next  = dest_reg;
                                out_pixel_next = (in_mbyte != '0) ? fill_reg : '0;
                                out_last_next  = final_px;
                                if (row_end)
                                begin
                                    dest_next = dest_reg + ROW_STEP - ADDR_W'(width_reg);
                                    col_next  = '0;
                                    row_next  = row_reg + 1'b1;
                                    if (final_px)
                                    begin
                                        busy_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    dest_next = dest_reg + 1'b1;
                                    col_next  = col_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WH:
            begin
                fill_next  = pal_rdata;
                acc_next   = mac_result;
                state_next = ST_SPR;
            end
            ST_SPR:
            begin
                acc_next   = mac_result;
                state_next = ST_DST;
            end
            ST_DST:
            begin
                dest_next  = mac_result;
                state_next = ST_PX;
            end
            ST_PX:
            begin
                dest_next  = mac_result;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FETCH;
                    out_addr_next  = acc_reg;
                    out_pixel_next = '0;
                    out_last_next  = 1'b0;
                    busy_next      = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            busy_reg        <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            out_valid_reg   <= 1'b0;
            screen_base_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                screen_base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        height_reg    <= height_next;
        sprite_reg    <= sprite_next;
        fill_reg      <= fill_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        mbase_reg     <= mbase_next;
        acc_reg       <= acc_next;
        dest_reg      <= dest_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pixel_reg, out_addr_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: hdl/mcb_checker.sv
// Port-level assertions for the masked cell blitter, bound to the top level.
// Depends on mcb_pkg and masked_cell_blitter.
module mcb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mcb_pkg::IN_W-1:0]      s_axis_tdata,
    input logic [mcb_pkg::CMD_W-1:0]     s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mcb_pkg::OUT_W-1:0]     m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);
    import mcb_pkg::*;

    logic start_nonempty;

    assign start_nonempty = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START)
                            && (s_axis_tdata[63:56] != '0) && (s_axis_tdata[71:64] != '0);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_nonempty |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input accepted during start sequence");

    a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PIXEL)
        else $error("tlast on a fetch transaction");

    a_fetch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FETCH) |-> m_axis_tdata[39:32] == '0)
        else $error("fetch transaction with nonzero pixel");

endmodule

bind masked_cell_blitter mcb_checker u_mcb_checker (.*);

FILE: dv/mcb_tb_pkg.sv
// Scoreboard for the masked cell blitter testbench: request and bus write types,
// a transaction-level model of the blitter and the queue of writes still due.
// Depends on mcb_pkg.
package mcb_tb_pkg;
    import mcb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // s_axis_tdata layout, lowest bits last in this list
    typedef struct packed {
        logic [7:0]  mask_byte;
        logic [31:0] mask_base;
        logic [7:0]  cell_height;
        logic [7:0]  cell_width;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
        logic [7:0]  sprite_index;
        logic [7:0]  palette_value;
        logic [7:0]  colour_index;
    } blit_req_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [7:0]  pixel;
        logic        last;
    } bus_write_t;

    class blit_scoreboard;
        logic [7:0]  palette [256];
        logic [31:0] screen_base;
        logic [31:0] dest_address;
        logic [7:0]  fill_colour;
        logic [7:0]  width_latched;
        logic [7:0]  height_latched;
        logic [7:0]  column_count;
        logic [7:0]  row_count;
        logic        busy;
        bus_write_t  pending_writes [$];
        int          mismatches;

        function new();
            foreach (palette[i])
                palette[i] = 8'h00;
            screen_base    = '0;
            dest_address   = '0;
            fill_colour    = '0;
            width_latched  = '0;
            height_latched = '0;
            column_count   = '0;
            row_count      = '0;
            busy           = 1'b0;
            mismatches     = 0;
        endfunction

        // accepted input transaction: update state, queue the write it causes
        function void note_request(logic [CMD_W-1:0] cmd, blit_req_t req);
            bus_write_t wr;
            logic       row_end;
            logic       final_px;
            wr = '0;
            case (cmd)
                CMD_LOAD:
                    palette[req.colour_index] = req.palette_value;
                CMD_START:
                begin
                    width_latched  = req.cell_width;
                    height_latched = req.cell_height;
                    fill_colour    = palette[req.colour_index];
                    dest_address   = screen_base + 32'(req.pos_y) * 32'(LINE_STRIDE)
                                     + 32'(req.pos_x);
                    column_count   = '0;
                    row_count      = '0;
                    if (req.cell_width == 0 || req.cell_height == 0)
                        busy = 1'b0;
                    else
                    begin
                        busy       = 1'b1;
                        wr.kind    = KIND_FETCH;
                        wr.address = 32'(req.sprite_index)
                                     * (32'(req.cell_width) * 32'(req.cell_height))
                                     + req.mask_base;
                        pending_writes.push_back(wr);
                    end
                end
                CMD_MASK:
                    if (busy)
                    begin
                        row_end    = 8'(column_count + 8'd1) == width_latched;
                        final_px   = row_end && 8'(row_count + 8'd1) == height_latched;
                        wr.kind    = KIND_PIXEL;
                        wr.address = dest_address;
                        wr.pixel   = (req.mask_byte != 0) ? fill_colour : 8'h00;
                        wr.last    = final_px;
                        pending_writes.push_back(wr);
                        dest_address = dest_address + 32'd1;
                        if (row_end)
                        begin
                            column_count = '0;
                            row_count    = row_count + 8'd1;
                            dest_address = dest_address + 32'(LINE_STRIDE)
                                           - 32'(width_latched);
                            if (final_px)
                                busy = 1'b0;
                        end
                        else
                            column_count = column_count + 8'd1;
                    end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_write(bus_write_t got);
            bus_write_t want;
            if (pending_writes.size() == 0)
            begin
                $error("unexpected output transaction: kind %0b address %0h pixel %0h",
                       got.kind, got.address, got.pixel);
                mismatches++;
                return;
            end
            want = pending_writes.pop_front();
            compare("kind", 32'(want.kind), 32'(got.kind));
            compare("address", want.address, got.address);
            compare("pixel", 32'(want.pixel), 32'(got.pixel));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

endpackage

FILE: dv/tb.sv
// Top-level testbench for masked_cell_blitter: directed and random command streams,
// random stalls on both streams, every output checked against blit_scoreboard.
// Depends on mcb_pkg, mcb_tb_pkg and the blitter RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcb_pkg::*;
    import mcb_tb_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [ADDR_W-1:0]   cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic [CMD_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    blit_scoreboard      sb;
    bus_write_t          seen;
    bit                  stall_on = 1'b1;
    int                  quiet_cycles = 0;

    masked_cell_blitter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= !stall_on || ($urandom_range(0, 99) >= 21);

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.kind    = m_axis_tuser;
                seen.address = m_axis_tdata[31:0];
                seen.pixel   = m_axis_tdata[39:32];
                seen.last    = m_axis_tlast;
                sb.check_write(seen);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, blit_req_t'(s_axis_tdata));
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic blit_req_t random_req();
        logic [127:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom()};
        return bits[111:0];
    endfunction

    // favor a few palette entries so loads and starts hit the same colours
    function automatic logic [7:0] pick_colour();
        if ($urandom_range(0, 99) < 70)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_mask_byte();
        if ($urandom_range(0, 99) < 40)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input blit_req_t req);
        while (stall_on && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_load(input logic [7:0] index, input logic [7:0] value);
        blit_req_t req;
        req               = random_req();
        req.colour_index  = index;
        req.palette_value = value;
        send_item(CMD_LOAD, req);
    endtask

    task automatic send_start(input logic [7:0] colour, input logic [7:0] sprite,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] w, input logic [7:0] h,
                              input logic [31:0] base);
        blit_req_t req;
        req              = random_req();
        req.colour_index = colour;
        req.sprite_index = sprite;
        req.pos_x        = x;
        req.pos_y        = y;
        req.cell_width   = w;
        req.cell_height  = h;
        req.mask_base    = base;
        send_item(CMD_START, req);
    endtask

    task automatic send_mask(input logic [7:0] value);
        blit_req_t req;
        req           = random_req();
        req.mask_byte = value;
        send_item(CMD_MASK, req);
    endtask

    // start a cell and feed stop_after of its mask bytes, loads mixed in now and then
    task automatic send_cell(input logic [7:0] w, input logic [7:0] h,
                             input int stop_after, inout int sent);
        send_start(pick_colour(), 8'($urandom), 16'($urandom), 16'($urandom), w, h,
                   $urandom());
        sent++;
        for (int k = 0; k < stop_after; k++)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                send_load(pick_colour(), 8'($urandom));
                sent++;
            end
            send_mask(random_mask_byte());
            sent++;
        end
    endtask

    task automatic pick_size(output logic [7:0] w, output logic [7:0] h);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            w = 8'($urandom_range(1, 6));
            h = 8'($urandom_range(1, 6));
        end
        else if (r < 95)
        begin
            w = 8'($urandom_range(7, 40));
            h = 8'($urandom_range(1, 3));
        end
        else
        begin
            w = 8'd1;
            h = 8'($urandom_range(7, 40));
        end
    endtask

    task automatic run_phase(input int target, input logic [7:0] big_w,
                             input logic [7:0] big_h);
        int         sent;
        int         r;
        int         n;
        logic [7:0] w;
        logic [7:0] h;
        bit         cell_open;
        sent      = 0;
        cell_open = 1'b0;
        if (big_w != 0)
            send_cell(big_w, big_h, int'(big_w) * int'(big_h), sent);
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                send_load(pick_colour(), 8'($urandom));
                sent++;
            end
            else if (r < 15)
            begin
                if ($urandom_range(0, 1))
                begin
                    w = 8'd0;
                    h = 8'($urandom_range(0, 255));
                end
                else
                begin
                    w = 8'($urandom_range(0, 255));
                    h = 8'd0;
                end
                send_start(pick_colour(), 8'($urandom), 16'($urandom), 16'($urandom),
                           w, h, $urandom());
                sent++;
                cell_open = 1'b0;
            end
            else if (r < 19)
            begin
                send_mask(random_mask_byte());
                sent++;
            end
            else
            begin
                pick_size(w, h);
                n = int'(w) * int'(h);
                if ($urandom_range(0, 99) < 10)
                begin
                    send_cell(w, h, $urandom_range(0, n - 1), sent);
                    cell_open = 1'b1;
                end
                else
                begin
                    send_cell(w, h, n, sent);
                    cell_open = 1'b0;
                end
            end
        end
        pick_size(w, h);
        send_cell(w, h, int'(w) * int'(h), sent);
    endtask

    // hold off the sender until every pending write has drained, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_screen_base(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.screen_base = value;
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset-value screen base, cleared palette, wraps, corner cases
        send_mask(8'hFF);
        send_item(CMD_UNUSED, random_req());
        send_start(8'd7, 8'd0, 16'd0, 16'd0, 8'd1, 8'd1, 32'h0);
        send_mask(8'hFF);
        send_load(8'd255, 8'hFF);
        send_load(8'd0, 8'hA5);
        send_start(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 8'd2, 8'd2, 32'hFFFF_FFFF);
        send_mask(8'h00);
        send_mask(8'h01);
        send_mask(8'h80);
        send_mask(8'hFF);
        send_start(8'd0, 8'd1, 16'd5, 16'd5, 8'd0, 8'd3, 32'h0);
        send_start(8'd0, 8'd1, 16'd5, 16'd5, 8'd4, 8'd0, 32'h0);
        send_mask(8'h55);
        send_start(8'd0, 8'd3, 16'd100, 16'd2, 8'd3, 8'd2, 32'h1000);
        send_mask(8'hAA);
        send_load(8'd0, 8'h3C);
        send_mask(8'h00);
        send_mask(8'h7F);
        send_start(8'd0, 8'd0, 16'hFFFF, 16'd0, 8'd1, 8'd2, 32'h0);
        send_mask(8'h01);
        send_mask(8'h02);
        send_item(CMD_UNUSED, random_req());
        settle();

        write_screen_base(32'hFFFF_FFFF);
        run_phase(270, 8'd255, 8'd1);
        settle();
        write_screen_base(32'h0);
        run_phase(270, 8'd1, 8'd255);
        settle();
        write_screen_base($urandom());
        stall_on = 1'b0;
        run_phase(270, 8'd0, 8'd0);
        settle();
        stall_on = 1'b1;
        write_screen_base(32'h8000_0000);
        run_phase(270, 8'd0, 8'd0);
        settle();
        write_screen_base($urandom());
        run_phase(200, 8'd0, 8'd0);
        settle();

        if (sb.mismatches == 0 && sb.pending_writes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
